[design/lhd_pkg.sv]
// lhd_pkg: shared types and constants of the labelled hex line decoder
// no dependencies; imported by lhd_step and labelled_hex_line_decoder
`default_nettype none

package lhd_pkg;

    localparam int MAX_BYTES  = 64;
    localparam int MAX_TEXT   = 65536;
    localparam int CNT_W      = 7;
    localparam int POS_W      = 17;
    localparam int LABEL_LEN  = 12;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_EQ    = 8'h3d;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_LABEL   = 4'd1,
        PH_PRE_EQ  = 4'd2,
        PH_POST_EQ = 4'd3,
        PH_HEX_HI  = 4'd4,
        PH_HEX_LO  = 4'd5,
        PH_TRAIL   = 4'd6,
        PH_CR_WAIT = 4'd7,
        PH_DONE    = 4'd8
    } t_phase;

    typedef struct packed {
        t_phase             phase;
        logic [3:0]         label_pos;
        logic [CNT_W-1:0]   digit_count;
        logic [3:0]         high_nibble;
        logic [POS_W-1:0]   char_pos;
    } t_state;

    typedef struct packed {
        logic               kind;
        logic [7:0]         data_byte;
        logic [5:0]         byte_index;
        logic               ok;
        logic [POS_W-1:0]   next_offset;
    } t_result;

    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

endpackage

`default_nettype wire

[design/lhd_step.sv]
// lhd_step: per-character parse step, next parser state and optional result word
// depends on lhd_pkg
`default_nettype none

module lhd_step
    import lhd_pkg::*;
(
    input  wire t_state           i_state,
    input  wire logic [7:0]       i_ch,
    input  wire logic             i_first,
    input  wire logic             i_last,
    input  wire logic [CNT_W-1:0] i_byte_count,
    output t_state                o_state,
    output logic                  o_res_valid,
    output t_result               o_res
);

    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(MAX_TEXT - 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_BYTES);
    localparam logic [3:0]       LABEL_END = 4'(LABEL_LEN);

    function automatic logic [7:0] label_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = "s";
            4'd1:    c = "e";
            4'd2:    c = "t";
            4'd3:    c = "u";
            4'd4:    c = "p";
            4'd5:    c = "D";
            4'd6:    c = "e";
            4'd7:    c = "t";
            4'd8:    c = "a";
            4'd9:    c = "i";
            4'd10:   c = "l";
            4'd11:   c = "s";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    logic [CNT_W-1:0] cnt;
    t_phase           b_phase;
    t_phase           ph_eff;
    logic [3:0]       b_lp;
    logic [CNT_W-1:0] b_dc;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] pos_inc;
    logic             go;
    logic             early_fail;
    logic             elast;
    logic             blank;
    logic             nib_ok;
    logic [3:0]       nib;
    logic             v_ok;
    logic             v_fail;
    logic [POS_W-1:0] v_off;
    logic             d_emit;
    logic             adv_label;
    logic             load_hi;
    logic             eq_seen;
    logic             to_crwait;
    logic             any_verdict;
    logic             fail_out;

    // character classes
    always_comb begin
        nib_ok = 1'b1;
        nib    = 4'd0;
        if (i_ch >= "0" && i_ch <= "9") begin
            nib = 4'(i_ch - "0");
        end else if (i_ch >= "a" && i_ch <= "f") begin
            nib = 4'(i_ch - "a" + 8'd10);
        end else if (i_ch >= "A" && i_ch <= "F") begin
            nib = 4'(i_ch - "A" + 8'd10);
        end else begin
            nib_ok = 1'b0;
        end
    end

    assign blank   = (i_ch == CH_SPACE) || (i_ch == CH_TAB);
    assign cnt     = (i_byte_count > CNT_LIMIT) ? CNT_LIMIT : i_byte_count;
    assign b_phase = i_first ? PH_LABEL : i_state.phase;
    assign b_lp    = i_first ? 4'd0 : i_state.label_pos;
    assign b_dc    = i_first ? '0 : i_state.digit_count;
    assign pos     = i_first ? '0 : i_state.char_pos;
    assign pos_inc = pos + POS_W'(1);
    assign elast   = i_last || (pos >= LAST_POS);

    assign early_fail = i_first && (cnt == '0);
    assign go = i_first ? (cnt != '0)
                        : !(i_state.phase == PH_IDLE || i_state.phase == PH_DONE);

    // hex field closes once the completed byte count reaches the limit
    assign ph_eff = ((b_phase == PH_POST_EQ || b_phase == PH_HEX_HI) && b_dc >= cnt)
                    ? PH_TRAIL : b_phase;

    // decode of the current character
    always_comb begin
        v_ok      = 1'b0;
        v_fail    = 1'b0;
        v_off     = '0;
        d_emit    = 1'b0;
        adv_label = 1'b0;
        load_hi   = 1'b0;
        eq_seen   = 1'b0;
        to_crwait = 1'b0;
        if (go) begin
            unique case (ph_eff)
                PH_CR_WAIT: begin
                    v_ok  = 1'b1;
                    v_off = (i_ch == CH_LF) ? pos_inc : pos;
                end
                PH_LABEL: begin
                    if (b_lp == 4'd0 && blank) begin
                        v_fail = 1'b0;
                    end else if (b_lp < LABEL_END && i_ch == label_char(b_lp)) begin
                        adv_label = 1'b1;
                    end else begin
                        v_fail = 1'b1;
                    end
                end
                PH_PRE_EQ: begin
                    if (!blank) begin
                        if (i_ch == CH_EQ) eq_seen = 1'b1;
                        else               v_fail  = 1'b1;
                    end
                end
                PH_POST_EQ: begin
                    if (!blank) begin
                        if (nib_ok) load_hi = 1'b1;
                        else        v_fail  = 1'b1;
                    end
                end
                PH_HEX_HI: begin
                    if (nib_ok) load_hi = 1'b1;
                    else        v_fail  = 1'b1;
                end
                PH_HEX_LO: begin
                    if (nib_ok) d_emit = 1'b1;
                    else        v_fail = 1'b1;
                end
                PH_TRAIL: begin
                    if (!blank) begin
                        if (i_ch == CH_CR) begin
                            if (elast) begin
                                v_ok  = 1'b1;
                                v_off = pos_inc;
                            end else begin
                                to_crwait = 1'b1;
                            end
                        end else if (i_ch == CH_LF) begin
                            v_ok  = 1'b1;
                            v_off = pos_inc;
                        end else if (i_ch == CH_NUL) begin
                            v_ok  = 1'b1;
                            v_off = pos;
                        end else begin
                            v_fail = 1'b1;
                        end
                    end
                end
                default: v_fail = 1'b1;
            endcase
        end
    end

    // end of buffer without a verdict is a failure and overrides a data byte
    assign fail_out    = early_fail || v_fail || (go && elast && !v_ok);
    assign any_verdict = fail_out || v_ok;

    // next state
    always_comb begin
        o_state = i_state;
        if (i_first) begin
            o_state.phase       = PH_LABEL;
            o_state.label_pos   = '0;
            o_state.digit_count = '0;
            o_state.high_nibble = '0;
            o_state.char_pos    = '0;
        end
        if (go) begin
            o_state.char_pos = pos_inc;
            o_state.phase    = ph_eff;
            if (adv_label) begin
                o_state.label_pos = b_lp + 4'd1;
                if (b_lp + 4'd1 >= LABEL_END) o_state.phase = PH_PRE_EQ;
            end
            if (eq_seen) o_state.phase = PH_POST_EQ;
            if (load_hi) begin
                o_state.high_nibble = nib;
                o_state.phase       = PH_HEX_LO;
            end
            if (d_emit) begin
                o_state.digit_count = b_dc + CNT_W'(1);
                o_state.phase = (b_dc + CNT_W'(1) >= cnt) ? PH_TRAIL : PH_HEX_HI;
            end
            if (to_crwait) o_state.phase = PH_CR_WAIT;
        end
        if (any_verdict) o_state.phase = PH_DONE;
    end

    // result word
    always_comb begin
        o_res       = '0;
        o_res_valid = any_verdict || d_emit;
        if (any_verdict) begin
            o_res.kind        = KIND_VERDICT;
            o_res.ok          = v_ok && !fail_out;
            o_res.next_offset = (v_ok && !fail_out) ? v_off : '0;
        end else begin
            o_res.kind       = KIND_DATA;
            o_res.data_byte  = {i_state.high_nibble, nib};
            o_res.byte_index = b_dc[5:0];
        end
    end

endmodule

`default_nettype wire

[design/labelled_hex_line_decoder.sv]
// labelled_hex_line_decoder: top level, input register, parser state, result register
// depends on lhd_pkg and lhd_step
//
// usage
//   characters enter on the input channel (i_in_valid / o_in_ready), one word per
//   character with i_ch, i_first (starts a new line decode) and i_last (final
//   character of the buffer). results leave on the output channel
//   (o_out_valid / i_out_ready): data bytes (o_kind 0) with their index, and one
//   verdict (o_kind 1) per line with o_ok and o_next_offset.
//   i_cfg_we / i_cfg_data write the expected byte count; write it only while idle
//   latency: a result word shows on o_out_valid one cycle after its character
//   is accepted (the accepting edge loads the input register, the next edge
//   loads the result register)
//   throughput: one character per cycle; the parse step is a single pass of
//   logic between the input register and the result register
//   stall: while a result waits in the output register and i_out_ready is low,
//   the input register holds its character and o_in_ready drops once it is full;
//   characters that give no result still pass only when the step may advance
//   reset: synchronous active-low i_rst_n empties both registers, returns the
//   parser to idle and sets the byte count to 1
`default_nettype none

module labelled_hex_line_decoder
    import lhd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CNT_W-1:0] i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [7:0]       i_ch,
    input  wire logic             i_first,
    input  wire logic             i_last,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic                  o_kind,
    output logic [7:0]            o_data_byte,
    output logic [5:0]            o_byte_index,
    output logic                  o_ok,
    output logic [POS_W-1:0]      o_next_offset
);

    logic [CNT_W-1:0] r_byte_count;
    logic             r_in_valid;
    logic [7:0]       r_ch;
    logic             r_first;
    logic             r_last;
    t_state           r_state;
    t_state           n_state;
    logic             r_out_valid;
    t_result          r_out;
    t_result          n_res;
    logic             n_res_valid;
    logic             advance;
    logic             in_take;

    // the step may run when the result register is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    lhd_step u_step (
        .i_state      (r_state),
        .i_ch         (r_ch),
        .i_first      (r_first),
        .i_last       (r_last),
        .i_byte_count (r_byte_count),
        .o_state      (n_state),
        .o_res_valid  (n_res_valid),
        .o_res        (n_res)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= CNT_W'(1);
        end else if (i_cfg_we) begin
            r_byte_count <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_ch    <= i_ch;
            r_first <= i_first;
            r_last  <= i_last;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase       <= PH_IDLE;
            r_state.label_pos   <= '0;
            r_state.digit_count <= '0;
            r_state.high_nibble <= '0;
            r_state.char_pos    <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_res_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_res_valid) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out.kind;
    assign o_data_byte   = r_out.data_byte;
    assign o_byte_index  = r_out.byte_index;
    assign o_ok          = r_out.ok;
    assign o_next_offset = r_out.next_offset;

endmodule

`default_nettype wire

[tb/labelled_hex_line_decoder_test.sv]
// labelled_hex_line_decoder_test: self-checking testbench for the labelled hex line decoder
// depends on lhd_pkg and labelled_hex_line_decoder, which needs lhd_step; needs nothing else to run
`timescale 1ns / 1ps

module labelled_hex_line_decoder_test;
    import lhd_pkg::*;

    // label text packed msb-first, char 0 in the top byte
    localparam logic [8*LABEL_LEN-1:0] LABEL_TEXT = "setupDetails";
    // stand-in for NUL inside table strings, since a string drops real NULs
    localparam logic [7:0] NUL_MARK = "#";
    localparam int DRAIN_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;

    typedef enum int {TERM_LF, TERM_CRLF, TERM_CR_THEN, TERM_NUL, TERM_CR_LAST} t_term;
    typedef enum int {FLAW_NONE, FLAW_BYTE, FLAW_CUT, FLAW_DROP, FLAW_LENGTH} t_flaw;

    // one directed line: byte count to load, text, and the verdict where it is obvious
    typedef struct {
        logic [CNT_W-1:0] count;
        bit               fresh;
        string            text;
        bit               end_last;
        bit               pinned;
        bit               pin_ok;
        int               pin_off;
    } t_line_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [CNT_W-1:0] i_cfg_data = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic [7:0]       i_ch = '0;
    logic             i_first = 1'b0;
    logic             i_last = 1'b0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic             o_kind;
    logic [7:0]       o_data_byte;
    logic [5:0]       o_byte_index;
    logic             o_ok;
    logic [POS_W-1:0] o_next_offset;

    labelled_hex_line_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_ch          (i_ch),
        .i_first       (i_first),
        .i_last        (i_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_data_byte   (o_data_byte),
        .o_byte_index  (o_byte_index),
        .o_ok          (o_ok),
        .o_next_offset (o_next_offset)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // parser state mirrored by the testbench
    t_phase           phase_now = PH_IDLE;
    logic [3:0]       label_at = '0;
    logic [CNT_W-1:0] bytes_done = '0;
    logic [3:0]       hi_nib = '0;
    logic [POS_W-1:0] char_at = '0;
    logic [CNT_W-1:0] byte_count_now = 7'd1;

    // decoded bytes and verdicts still owed by the block, oldest first
    t_result awaited_words [$];

    int  mismatches = 0;
    int  words_checked = 0;
    int  verdicts = 0;
    int  good_verdicts = 0;
    int  chars_sent = 0;
    int  lines_started = 0;
    bit  verdict_seen = 1'b0;
    bit  last_ok = 1'b0;
    int  last_off = 0;
    // steady turns off idling on both sides
    bit  steady = 1'b0;

    function automatic logic [7:0] label_char(input int idx);
        return LABEL_TEXT[8*(LABEL_LEN-1-idx) +: 8];
    endfunction

    function automatic void log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function automatic string show_word(input t_result w);
        return $sformatf("kind %0d byte %02h index %0d ok %0d offset %0d",
                         w.kind, w.data_byte, w.byte_index, w.ok, w.next_offset);
    endfunction

    // verdict ends the line; everything up to the next first is ignored
    function automatic void close_line(input bit good, input logic [POS_W-1:0] offset);
        t_result word;
        word = '0;
        word.kind = KIND_VERDICT;
        word.ok = good;
        word.next_offset = good ? offset : '0;
        awaited_words.push_back(word);
        phase_now = PH_DONE;
    endfunction

    // one accepted character: advance the mirrored parser, queue what it yields
    function automatic void decode_char(input logic [7:0] ch, input bit is_first,
                                        input bit is_last);
        t_result          word;
        int               cnt;
        logic [POS_W-1:0] pos;
        logic [3:0]       nib;
        bit               nib_ok;
        bit               blank;
        bit               at_end;
        bit               has_byte;
        // counts above the buffer size act as the buffer size
        cnt = (int'(byte_count_now) > MAX_BYTES) ? MAX_BYTES : int'(byte_count_now);
        word = '0;
        has_byte = 1'b0;
        if (is_first) begin
            phase_now = PH_LABEL;
            label_at = '0;
            bytes_done = '0;
            hi_nib = '0;
            char_at = '0;
            if (cnt == 0) begin
                close_line(1'b0, '0);
                return;
            end
        end else if (phase_now == PH_IDLE || phase_now >= PH_DONE) begin
            return;
        end
        pos = char_at;
        char_at = pos + 1'b1;
        // the last slot of the buffer counts as its end
        at_end = is_last || int'(pos) >= MAX_TEXT - 1;
        blank = (ch == CH_SPACE) || (ch == CH_TAB);
        nib_ok = 1'b1;
        nib = '0;
        if (ch >= "0" && ch <= "9") nib = 4'(ch - "0");
        else if (ch >= "a" && ch <= "f") nib = 4'(ch - "a" + 8'd10);
        else if (ch >= "A" && ch <= "F") nib = 4'(ch - "A" + 8'd10);
        else nib_ok = 1'b0;
        // a count lowered mid-line closes the hex field early
        if ((phase_now == PH_POST_EQ || phase_now == PH_HEX_HI) && int'(bytes_done) >= cnt)
            phase_now = PH_TRAIL;
        case (phase_now)
            PH_CR_WAIT: begin
                close_line(1'b1, (ch == CH_LF) ? pos + 1'b1 : pos);
                return;
            end
            PH_LABEL: begin
                if (!(label_at == 0 && blank)) begin
                    if (label_at < LABEL_LEN && ch == label_char(label_at)) begin
                        label_at++;
                        if (label_at >= LABEL_LEN) phase_now = PH_PRE_EQ;
                    end else begin
                        close_line(1'b0, '0);
                        return;
                    end
                end
            end
            PH_PRE_EQ: begin
                if (!blank) begin
                    if (ch == CH_EQ) begin
                        phase_now = PH_POST_EQ;
                    end else begin
                        close_line(1'b0, '0);
                        return;
                    end
                end
            end
            PH_POST_EQ, PH_HEX_HI: begin
                // blanks only between '=' and the first digit
                if (!(phase_now == PH_POST_EQ && blank)) begin
                    if (!nib_ok) begin
                        close_line(1'b0, '0);
                        return;
                    end
                    hi_nib = nib;
                    phase_now = PH_HEX_LO;
                end
            end
            PH_HEX_LO: begin
                if (!nib_ok) begin
                    close_line(1'b0, '0);
                    return;
                end
                word.kind = KIND_DATA;
                word.data_byte = {hi_nib, nib};
                word.byte_index = bytes_done[5:0];
                has_byte = 1'b1;
                bytes_done++;
                phase_now = (int'(bytes_done) >= cnt) ? PH_TRAIL : PH_HEX_HI;
            end
            PH_TRAIL: begin
                if (!blank) begin
                    if (ch == CH_CR && at_end) begin
                        close_line(1'b1, pos + 1'b1);
                    end else if (ch == CH_CR) begin
                        // lone CR waits one character for an LF
                        phase_now = PH_CR_WAIT;
                    end else if (ch == CH_LF) begin
                        close_line(1'b1, pos + 1'b1);
                    end else if (ch == CH_NUL) begin
                        // NUL stays unconsumed, offset points at it
                        close_line(1'b1, pos);
                    end else begin
                        close_line(1'b0, '0);
                    end
                    return;
                end
            end
            default: begin
                close_line(1'b0, '0);
                return;
            end
        endcase
        // buffer ran out with no verdict: failure replaces any byte just completed
        if (at_end) begin
            close_line(1'b0, '0);
            return;
        end
        if (has_byte) awaited_words.push_back(word);
    endfunction

    // monitor: results are checked first, then the accepted character is decoded
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = {o_kind, o_data_byte, o_byte_index, o_ok, o_next_offset};
                words_checked++;
                if (awaited_words.size() == 0) begin
                    log_mismatch($sformatf("word with nothing pending: %s", show_word(got)));
                end else begin
                    want = awaited_words.pop_front();
                    if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                        got.byte_index !== want.byte_index || got.ok !== want.ok ||
                        got.next_offset !== want.next_offset)
                        log_mismatch($sformatf("expected %s, got %s",
                                               show_word(want), show_word(got)));
                end
                if (got.kind == KIND_VERDICT) begin
                    verdict_seen = 1'b1;
                    last_ok = got.ok;
                    last_off = int'(got.next_offset);
                    verdicts++;
                    if (got.ok) good_verdicts++;
                end
            end
            if (i_in_valid && o_in_ready) decode_char(i_ch, i_first, i_last);
        end
    end

    // receiver stalls at random, with odds of about 38 in 100, unless steady
    always @(negedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= 38);
    end

    // sender: optional idle cycles first, then hold the word until it is taken
    task automatic send_char(input logic [7:0] ch, input bit is_first, input bit is_last);
        while (!steady && $urandom_range(99) < 38) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ch <= ch;
        i_first <= is_first;
        i_last <= is_last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        chars_sent++;
        if (is_first) lines_started++;
    endtask

    // stop sending, wait out every owed word, then let characters without results settle
    task automatic drain_results();
        int n;
        i_in_valid <= 1'b0;
        for (n = 0; n < DRAIN_LIMIT && awaited_words.size() != 0; n++) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // only called at a falling edge with no results owed and no character offered
    task automatic set_byte_count(input logic [CNT_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        byte_count_now = value;
    endtask

    task automatic check_verdict(input bit good, input int offset, input string what);
        if (!verdict_seen || last_ok != good || last_off != offset)
            log_mismatch($sformatf("%s: verdict ok %0d offset %0d wanted, seen %0d ok %0d offset %0d",
                                   what, good, offset, verdict_seen, last_ok, last_off));
    endtask

    function automatic logic [7:0] pick_blank();
        return $urandom_range(1) ? CH_SPACE : CH_TAB;
    endfunction

    // hex digit in either case
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 10) return 8'("0" + v);
        return 8'(($urandom_range(1) ? "A" : "a") + v - 8'd10);
    endfunction

    // mostly well-formed lines with random spacing, digits and terminators;
    // about a quarter carry a flaw
    task automatic send_random_line(input int cnt_eff);
        logic [7:0] text [$];
        int         npairs;
        int         end_at;
        int         k;
        t_term      term;
        t_flaw      flaw;
        flaw = ($urandom_range(99) < 25) ? t_flaw'($urandom_range(1, 4)) : FLAW_NONE;
        npairs = cnt_eff;
        if (flaw == FLAW_LENGTH)
            npairs = ($urandom_range(1) && cnt_eff > 0) ? cnt_eff - 1 : cnt_eff + 1;
        end_at = -1;
        repeat ($urandom_range(2)) text.push_back(pick_blank());
        for (k = 0; k < LABEL_LEN; k++) text.push_back(label_char(k));
        repeat ($urandom_range(2)) text.push_back(pick_blank());
        text.push_back(CH_EQ);
        repeat ($urandom_range(2)) text.push_back(pick_blank());
        for (k = 0; k < npairs; k++) begin
            text.push_back(hex_char(4'($urandom_range(15))));
            text.push_back(hex_char(4'($urandom_range(15))));
        end
        repeat ($urandom_range(2)) text.push_back(pick_blank());
        term = t_term'($urandom_range(4));
        case (term)
            TERM_LF: text.push_back(CH_LF);
            TERM_CRLF: begin
                text.push_back(CH_CR);
                text.push_back(CH_LF);
            end
            TERM_CR_THEN: begin
                text.push_back(CH_CR);
                text.push_back(8'($urandom_range(255)));
            end
            TERM_NUL: text.push_back(CH_NUL);
            default: begin
                text.push_back(CH_CR);
                end_at = text.size() - 1;
            end
        endcase
        case (flaw)
            FLAW_BYTE: text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
            FLAW_CUT, FLAW_DROP: begin
                // cut short: either marked as the buffer end or simply abandoned
                k = $urandom_range(text.size() - 1);
                while (text.size() > k + 1) void'(text.pop_back());
                end_at = (flaw == FLAW_CUT) ? k : -1;
            end
            default: begin
                if ($urandom_range(99) < 4) end_at = $urandom_range(text.size() - 1);
            end
        endcase
        for (k = 0; k < text.size(); k++) send_char(text[k], k == 0, k == end_at);
    endtask

    // directed lines; '#' stands for NUL, offsets count from the line's first character
    t_line_row line_table [16] = '{
        // strays before any decode are ignored
        '{7'd1,   1'b0, "zq",                                1'b0, 1'b0, 1'b0, 0},
        '{7'd1,   1'b1, "setupDetails=AB\n",                 1'b0, 1'b1, 1'b1, 16},
        '{7'd2,   1'b1, " \tsetupDetails \t= \t00ff \015\n", 1'b0, 1'b1, 1'b1, 26},
        // lone CR, next char is not an LF
        '{7'd1,   1'b1, "setupDetails=Fa\015x",              1'b0, 1'b1, 1'b1, 16},
        '{7'd1,   1'b1, "setupDetails=9c#",                  1'b0, 1'b1, 1'b1, 15},
        // CR as the final buffer character
        '{7'd1,   1'b1, "setupDetails=7E\015",               1'b1, 1'b1, 1'b1, 16},
        // label mismatch, the rest of the line goes unheeded
        '{7'd1,   1'b1, "setupdetails=00\n",                 1'b0, 1'b1, 1'b0, 0},
        '{7'd1,   1'b1, "setupDetails=1g\n",                 1'b0, 1'b1, 1'b0, 0},
        // buffer ends on the digit that completes the byte
        '{7'd1,   1'b1, "setupDetails=12",                   1'b1, 1'b1, 1'b0, 0},
        '{7'd0,   1'b1, "setupDetails=00\n",                 1'b0, 1'b1, 1'b0, 0},
        // count lowered from 3 to 1 after the first byte
        '{7'd3,   1'b1, "setupDetails = AB",                 1'b0, 1'b0, 1'b0, 0},
        '{7'd1,   1'b0, "\t\n",                              1'b0, 1'b1, 1'b1, 19},
        '{7'd1,   1'b1, "setupDetails=AB x\n",               1'b0, 1'b1, 1'b0, 0},
        '{7'd1,   1'b1, "setupDetails AB\n",                 1'b0, 1'b1, 1'b0, 0},
        '{7'd127, 1'b1, "setupDetails=",                     1'b1, 1'b1, 1'b0, 0},
        '{7'd64,  1'b1, "x",                                 1'b0, 1'b1, 1'b0, 0}
    };

    // byte counts for the random phases; one slot gets a random small value
    int phase_counts [8] = '{1, 2, 8, 127, 0, 5, 1, 3};

    initial begin
        int         k;
        int         p;
        int         eff;
        int         start;
        logic [7:0] c;
        // synchronous reset held low, then released at a falling edge
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (line_table[r]) begin
            set_byte_count(line_table[r].count);
            verdict_seen = 1'b0;
            for (k = 0; k < line_table[r].text.len(); k++) begin
                c = line_table[r].text[k];
                if (c == NUL_MARK) c = CH_NUL;
                send_char(c, line_table[r].fresh && k == 0,
                          line_table[r].end_last && k == line_table[r].text.len() - 1);
            end
            // sender waits here for every owed word before the next line
            drain_results();
            if (line_table[r].pinned)
                check_verdict(line_table[r].pin_ok, line_table[r].pin_off,
                              $sformatf("directed line %0d", r));
        end

        // random lines across several byte counts; the clamped phase runs without idling
        phase_counts[6] = $urandom_range(1, 8);
        for (p = 0; p < 8; p++) begin
            drain_results();
            set_byte_count(CNT_W'(phase_counts[p]));
            steady = (phase_counts[p] >= MAX_BYTES);
            eff = (phase_counts[p] > MAX_BYTES) ? MAX_BYTES : phase_counts[p];
            start = chars_sent;
            do begin
                // occasional stray characters between lines
                if ($urandom_range(99) < 10)
                    repeat ($urandom_range(1, 3))
                        send_char(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
                send_random_line(eff);
            end while (chars_sent - start < ((eff > 16) ? 1 : 20));
        end
        steady = 1'b0;
        drain_results();

        if (awaited_words.size() != 0)
            log_mismatch($sformatf("%0d words never arrived", awaited_words.size()));
        $display("sent %0d characters over %0d line starts, byte counts 0 to 127", chars_sent,
                 lines_started);
        $display("checked %0d result words, %0d verdicts (%0d good), %0d mismatches",
                 words_checked, verdicts, good_verdicts, mismatches);
        if (mismatches == 0) begin
            $display("labelled_hex_line_decoder verification clean");
        end else begin
            $display("labelled_hex_line_decoder verification failed");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("labelled_hex_line_decoder verification failed");
        $finish;
    end

endmodule
